// ===== src/nearest_nonzero_texel_search_unit_macros.svh =====
// Assertion macros for the nearest nonzero texel search unit.
// Expects clk and rst_n in the scope of use.
`ifndef NEAREST_NONZERO_TEXEL_SEARCH_UNIT_MACROS_SVH
`define NEAREST_NONZERO_TEXEL_SEARCH_UNIT_MACROS_SVH

// Same-cycle implication, off while in reset.
`define NNTS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define NNTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/nnts_pkg.sv =====
// Shared types, sizes and codes of the nearest nonzero texel search unit.
// No dependencies.
package nnts_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int MAX_RADIUS = 15;

  localparam int XW      = $clog2(MAX_WIDTH);
  localparam int YW      = $clog2(MAX_HEIGHT);
  localparam int ADDR_W  = XW + YW;
  localparam int DEPTH   = 1 << ADDR_W;

  localparam int WORD_W  = 32;
  localparam int POS_W   = 8;
  localparam int RAD_W   = 4;
  localparam int OFS_W   = 5;
  localparam int COORD_W = 10;
  localparam int CFG_W   = 7;
  localparam int SLOT_W  = 3;

  localparam logic [CFG_W-1:0] WIN_RESET = CFG_W'(64);

  localparam logic REG_WIN_WIDTH  = 1'b0;
  localparam logic REG_WIN_HEIGHT = 1'b1;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0] id;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } texel_t;

  typedef struct packed {
    logic                    vld;
    logic                    last;
    logic signed [OFS_W-1:0] dx;
    logic signed [OFS_W-1:0] dy;
  } cand_t;

endpackage

// ===== src/nnts_texel_ram.sv =====
// Texel store: one write port, one read port with registered read data.
// Depends on nnts_pkg.
module nnts_texel_ram
  import nnts_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  texel_t            wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output texel_t            rdata
);

  texel_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/nnts_ring_walker.sv =====
// Offset sequencer: rings of growing Chebyshev distance, one offset a cycle, ordered by
// ring, then squared distance within the ring, then row, then column. Depends on nnts_pkg.
module nnts_ring_walker
  import nnts_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic [RAD_W-1:0] radius,
  input  logic             halt,
  output cand_t            cand
);

  logic              active_r, active_nxt;
  logic [RAD_W-1:0]  d_r, d_nxt;
  logic [RAD_W-1:0]  m_r, m_nxt;
  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  logic [7:0]        mask;
  logic              more;
  logic [SLOT_W-1:0] next_slot;
  logic              pair_last;
  logic              last;
  logic signed [OFS_W-1:0] pd, pm;

  always_comb begin
    mask[0] = 1'b1;
    mask[1] = (m_r != '0);
    mask[2] = (m_r != d_r);
    mask[3] = (m_r != d_r);
    mask[4] = (m_r != '0) && (m_r != d_r);
    mask[5] = (m_r != '0) && (m_r != d_r);
    mask[6] = (d_r != '0);
    mask[7] = (m_r != '0);
  end

  always_comb begin
    more      = 1'b0;
    next_slot = slot_r;
    for (int i = 7; i >= 0; i--) begin
      if (mask[i] && (SLOT_W'(i) > slot_r)) begin
        more      = 1'b1;
        next_slot = SLOT_W'(i);
      end
    end
  end

  assign pair_last = (m_r == d_r);
  assign last      = !more && pair_last && (d_r == rad_r);

  assign pd = $signed({1'b0, d_r});
  assign pm = $signed({1'b0, m_r});

  always_comb begin
    cand.vld  = active_r;
    cand.last = last;
    unique case (slot_r)
      3'd0:    begin cand.dx = -pm; cand.dy = -pd; end
      3'd1:    begin cand.dx =  pm; cand.dy = -pd; end
      3'd2:    begin cand.dx = -pd; cand.dy = -pm; end
      3'd3:    begin cand.dx =  pd; cand.dy = -pm; end
      3'd4:    begin cand.dx = -pd; cand.dy =  pm; end
      3'd5:    begin cand.dx =  pd; cand.dy =  pm; end
      3'd6:    begin cand.dx = -pm; cand.dy =  pd; end
      default: begin cand.dx =  pm; cand.dy =  pd; end
    endcase
  end

  always_comb begin
    active_nxt = active_r;
    d_nxt      = d_r;
    m_nxt      = m_r;
    rad_nxt    = rad_r;
    slot_nxt   = slot_r;
    priority if (load) begin
      active_nxt = 1'b1;
      d_nxt      = '0;
      m_nxt      = '0;
      slot_nxt   = '0;
      rad_nxt    = radius;
    end else if (active_r) begin
      priority if (halt || last) begin
        active_nxt = 1'b0;
      end else if (more) begin
        slot_nxt = next_slot;
      end else if (pair_last) begin
        d_nxt    = d_r + 1'b1;
        m_nxt    = '0;
        slot_nxt = '0;
      end else begin
        m_nxt    = m_r + 1'b1;
        slot_nxt = '0;
      end
    end else begin
      active_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
    d_r    <= d_nxt;
    m_r    <= m_nxt;
    rad_r  <= rad_nxt;
    slot_r <= slot_nxt;
  end

endmodule

// ===== src/nearest_nonzero_texel_search_unit.sv =====
// Nearest nonzero texel search unit. A write request is accepted while idle and busy stays low.
// A search issues one offset a cycle, ring by ring, through one store read port.
// Each offset is checked against the registered read data: a nonzero id inside the
// window is a hit, a miss follows the last offset; busy drops as the result is registered.
// Synchronous active-low reset clears control and sets both window sizes to 64; the
// texel store is not cleared. Results strobe for one cycle and cannot be held off.
`include "nearest_nonzero_texel_search_unit_macros.svh"

module nearest_nonzero_texel_search_unit
  import nnts_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_command,
  input  logic signed [POS_W-1:0]  in_pos_x,
  input  logic signed [POS_W-1:0]  in_pos_y,
  input  logic [WORD_W-1:0]        in_word_id,
  input  logic [WORD_W-1:0]        in_word_a,
  input  logic [WORD_W-1:0]        in_word_b,
  input  logic [RAD_W-1:0]         in_search_radius,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  output logic                     out_valid,
  output logic                     out_found,
  output logic [WORD_W-1:0]        out_hit_id,
  output logic [WORD_W-1:0]        out_hit_a,
  output logic [WORD_W-1:0]        out_hit_b,
  output logic signed [OFS_W-1:0]  out_offset_x,
  output logic signed [OFS_W-1:0]  out_offset_y
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r, state_nxt;

  logic [CFG_W-1:0] win_w_r, win_h_r;
  logic [CFG_W-1:0] eff_w, eff_h;

  logic signed [POS_W-1:0] cen_x_r, cen_y_r;

  logic accept, accept_write, accept_search;
  logic [RAD_W-1:0] radius_sat;

  cand_t cand;
  logic signed [COORD_W-1:0] cand_x, cand_y, wr_x, wr_y;
  logic cand_inwin, wr_inwin;

  logic chk_vld_r, chk_last_r, chk_inwin_r;
  logic signed [OFS_W-1:0] chk_dx_r, chk_dy_r;

  texel_t rd_texel, wr_texel;
  logic hit, miss;

  logic out_valid_r, out_found_r;
  logic [WORD_W-1:0] out_id_r, out_a_r, out_b_r;
  logic signed [OFS_W-1:0] out_dx_r, out_dy_r;

  function automatic logic in_window(input logic signed [COORD_W-1:0] x,
                                     input logic signed [COORD_W-1:0] y,
                                     input logic [CFG_W-1:0] w,
                                     input logic [CFG_W-1:0] h);
    logic x_ok, y_ok;
    x_ok = !x[COORD_W-1] && ($unsigned(x) < COORD_W'(w));
    y_ok = !y[COORD_W-1] && ($unsigned(y) < COORD_W'(h));
    return x_ok && y_ok;
  endfunction

  assign busy      = (state_r == ST_RUN);
  assign cfg_ready = 1'b1;

  assign eff_w = (win_w_r > CFG_W'(MAX_WIDTH))  ? CFG_W'(MAX_WIDTH)  : win_w_r;
  assign eff_h = (win_h_r > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : win_h_r;

  assign accept        = start && !busy;
  assign accept_write  = accept && (in_command == CMD_WRITE);
  assign accept_search = accept && (in_command == CMD_SEARCH);

  assign radius_sat = (in_search_radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
                                                             : in_search_radius;

  // window configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_w_r <= WIN_RESET;
      win_h_r <= WIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WIN_WIDTH:  win_w_r <= cfg_data;
        REG_WIN_HEIGHT: win_h_r <= cfg_data;
        default:        win_w_r <= win_w_r;
      endcase
    end
  end

  // write path
  assign wr_x     = COORD_W'(in_pos_x);
  assign wr_y     = COORD_W'(in_pos_y);
  assign wr_inwin = in_window(wr_x, wr_y, eff_w, eff_h);
  assign wr_texel = '{id: in_word_id, a: in_word_a, b: in_word_b};

  // candidate generation
  nnts_ring_walker u_walker (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (accept_search),
    .radius (radius_sat),
    .halt   (hit),
    .cand   (cand)
  );

  assign cand_x     = COORD_W'(cen_x_r) + COORD_W'(cand.dx);
  assign cand_y     = COORD_W'(cen_y_r) + COORD_W'(cand.dy);
  assign cand_inwin = in_window(cand_x, cand_y, eff_w, eff_h);

  nnts_texel_ram u_store (
    .clk   (clk),
    .we    (accept_write && wr_inwin),
    .waddr ({wr_y[YW-1:0], wr_x[XW-1:0]}),
    .wdata (wr_texel),
    .re    (cand.vld),
    .raddr ({cand_y[YW-1:0], cand_x[XW-1:0]}),
    .rdata (rd_texel)
  );

  // check stage, aligned with read data
  assign hit  = chk_vld_r && chk_inwin_r && (rd_texel.id != '0);
  assign miss = chk_vld_r && chk_last_r && !hit;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept_search) begin
        state_nxt = ST_RUN;
      end
      default: if (hit || miss) begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chk_vld_r   <= cand.vld && !hit;
      out_valid_r <= hit || miss;
    end
    if (accept_search) begin
      cen_x_r <= in_pos_x;
      cen_y_r <= in_pos_y;
    end
    chk_last_r  <= cand.last;
    chk_inwin_r <= cand_inwin;
    chk_dx_r    <= cand.dx;
    chk_dy_r    <= cand.dy;
    if (hit) begin
      out_found_r <= 1'b1;
      out_id_r    <= rd_texel.id;
      out_a_r     <= rd_texel.a;
      out_b_r     <= rd_texel.b;
      out_dx_r    <= chk_dx_r;
      out_dy_r    <= chk_dy_r;
    end else if (miss) begin
      out_found_r <= 1'b0;
      out_id_r    <= '0;
      out_a_r     <= '0;
      out_b_r     <= '0;
      out_dx_r    <= '0;
      out_dy_r    <= '0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_hit_id   = out_id_r;
  assign out_hit_a    = out_a_r;
  assign out_hit_b    = out_b_r;
  assign out_offset_x = out_dx_r;
  assign out_offset_y = out_dy_r;

  `NNTS_ASSERT_NEXT(a_strobe_single, out_valid_r, !out_valid_r, "result strobe held")
  `NNTS_ASSERT_NEXT(a_search_busy, accept_search, state_r == ST_RUN, "search not started")
  `NNTS_ASSERT_IMPLY(a_check_in_run, chk_vld_r, state_r == ST_RUN, "check outside search")
  `NNTS_ASSERT_IMPLY(a_result_idle, out_valid_r, state_r == ST_IDLE, "busy after result")
  `NNTS_ASSERT_IMPLY(a_miss_zero, out_valid_r && !out_found_r,
                     (out_id_r == '0) && (out_dx_r == '0) && (out_dy_r == '0),
                     "miss result not cleared")

endmodule
